@@ rtl/hbkt_pkg.sv @@
`default_nettype none

package hbkt_pkg;

    // operation codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // configuration register indexes
    typedef enum logic {
        CFG_BUCKET_COUNT = 1'b0,
        CFG_WAYS_IN_USE  = 1'b1
    } t_cfg_idx;

    localparam int OP_W         = 2;
    localparam int KEY_IN_W     = 32;
    localparam int BUCKET_CFG_W = 11;
    localparam int WAYS_CFG_W   = 4;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int SLOT_OUT_W   = 13;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [BUCKET_CFG_W-1:0] BUCKET_COUNT_RESET = 11'd1024;
    localparam logic [WAYS_CFG_W-1:0]   WAYS_IN_USE_RESET  = 4'd5;

endpackage

`default_nettype wire

@@ rtl/hbkt_front.sv @@
`default_nettype none

module hbkt_front #(
    parameter int NUM_BUCKETS = 1024,
    parameter int MAX_WAYS    = 8,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [hbkt_pkg::BUCKET_CFG_W-1:0] i_bucket_count,
    input  wire logic [hbkt_pkg::WAYS_CFG_W-1:0]   i_ways_in_use,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [hbkt_pkg::OP_W-1:0]         i_op,
    input  wire logic [hbkt_pkg::KEY_IN_W-1:0]     i_key,
    input  wire logic                              i_hold,
    output logic                                   o_push,
    output logic [hbkt_pkg::OP_W + ((KEY_WIDTH < hbkt_pkg::KEY_IN_W) ? KEY_WIDTH :
                  hbkt_pkg::KEY_IN_W) + $clog2(MAX_WAYS + 1) +
                  ((NUM_BUCKETS * MAX_WAYS > 1) ? $clog2(NUM_BUCKETS * MAX_WAYS) : 1)
                  - 1:0]                           o_entry,
    input  wire logic                              i_full
);

    localparam int KW    = (KEY_WIDTH < hbkt_pkg::KEY_IN_W) ? KEY_WIDTH : hbkt_pkg::KEY_IN_W;
    localparam int DW    = $clog2(NUM_BUCKETS + 1);
    localparam int WW    = $clog2(MAX_WAYS + 1);
    localparam int DEPTH = NUM_BUCKETS * MAX_WAYS;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(KW + 1);
    localparam int PW    = DW + WW;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_PUSH} t_state;

    t_state                    r_state;
    logic [hbkt_pkg::OP_W-1:0] r_op;
    logic [KW-1:0]             r_key;
    logic [KW-1:0]             r_dvd;
    logic [DW-1:0]             r_rem;
    logic [DW-1:0]             r_div;
    logic [WW-1:0]             r_ways;
    logic [CW-1:0]             r_cnt;
    logic [SW-1:0]             r_base;

    logic [DW-1:0] w_eff_b;
    logic [WW-1:0] w_eff_w;
    logic [DW:0]   w_shift;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [PW-1:0] w_prod;

    always_comb begin
        if (i_bucket_count == '0) begin
            w_eff_b = DW'(1);
        end else if (32'(i_bucket_count) > NUM_BUCKETS) begin
            w_eff_b = DW'(NUM_BUCKETS);
        end else begin
            w_eff_b = DW'(i_bucket_count);
        end
        if (i_ways_in_use == '0) begin
            w_eff_w = WW'(1);
        end else if (32'(i_ways_in_use) > MAX_WAYS) begin
            w_eff_w = WW'(MAX_WAYS);
        end else begin
            w_eff_w = WW'(i_ways_in_use);
        end
    end

    // restoring remainder, one key bit per cycle, MSB first
    assign w_shift = {r_rem, r_dvd[KW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign n_rem   = w_ge ? DW'(w_shift - {1'b0, r_div}) : w_shift[DW-1:0];
    assign w_prod  = PW'(r_rem) * PW'(r_ways);

    assign o_in_ready = (r_state == S_IDLE) && !i_hold;
    assign o_push     = (r_state == S_PUSH) && !i_full;
    assign o_entry    = {r_op, r_key, r_ways, r_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_op   <= i_op;
                        r_key  <= i_key[KW-1:0];
                        r_dvd  <= i_key[KW-1:0];
                        r_rem  <= '0;
                        r_div  <= w_eff_b;
                        r_ways <= w_eff_w;
                        r_cnt  <= '0;
                        r_base <= '0;
                        unique case (i_op) inside
                            hbkt_pkg::OP_FIND, hbkt_pkg::OP_INSERT: r_state <= S_DIV;
                            default:                                r_state <= S_PUSH;
                        endcase
                    end
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[KW-2:0], 1'b0};
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(KW - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_base  <= SW'(w_prod);
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/hbkt_fifo.sv @@
`default_nettype none

module hbkt_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hbkt_back.sv @@
`default_nettype none

module hbkt_back #(
    parameter int NUM_BUCKETS = 1024,
    parameter int MAX_WAYS    = 8,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [hbkt_pkg::OP_W + ((KEY_WIDTH < hbkt_pkg::KEY_IN_W) ? KEY_WIDTH :
                       hbkt_pkg::KEY_IN_W) + $clog2(MAX_WAYS + 1) +
                       ((NUM_BUCKETS * MAX_WAYS > 1) ? $clog2(NUM_BUCKETS * MAX_WAYS) : 1)
                       - 1:0]                      i_entry,
    input  wire logic                              i_empty,
    output logic                                   o_pop,
    output logic                                   o_init_busy,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_out_hit,
    output logic [hbkt_pkg::SLOT_OUT_W-1:0]        o_out_slot
);

    localparam int KW    = (KEY_WIDTH < hbkt_pkg::KEY_IN_W) ? KEY_WIDTH : hbkt_pkg::KEY_IN_W;
    localparam int WW    = $clog2(MAX_WAYS + 1);
    localparam int DEPTH = NUM_BUCKETS * MAX_WAYS;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = hbkt_pkg::OP_W + KW + WW + SW;

    typedef enum logic [2:0] {S_INIT, S_IDLE, S_RD, S_CHK, S_CLR, S_FIN} t_state;

    t_state                            r_state;
    logic [hbkt_pkg::OP_W-1:0]         r_op;
    logic [KW-1:0]                     r_key;
    logic [WW-1:0]                     r_ways;
    logic [WW-1:0]                     r_way;
    logic [SW-1:0]                     r_addr;
    logic [SW-1:0]                     r_clr;
    logic                              r_hit;
    logic [SW-1:0]                     r_slot;
    logic                              r_out_valid;
    logic                              r_out_hit;
    logic [hbkt_pkg::SLOT_OUT_W-1:0]   r_out_slot;

    // slot store: {valid, key}
    logic [KW:0] r_mem [DEPTH];
    logic [KW:0] r_rd_data;

    logic [hbkt_pkg::OP_W-1:0] w_e_op;
    logic [KW-1:0]             w_e_key;
    logic [WW-1:0]             w_e_ways;
    logic [SW-1:0]             w_e_base;
    logic                      w_vld;
    logic                      w_match;
    logic                      w_last;
    logic                      w_clr_end;
    logic                      w_insert;
    logic                      w_we;
    logic [SW-1:0]             w_waddr;
    logic [KW:0]               w_wdata;

    assign w_e_op   = i_entry[EW-1 -: hbkt_pkg::OP_W];
    assign w_e_key  = i_entry[WW+SW +: KW];
    assign w_e_ways = i_entry[SW +: WW];
    assign w_e_base = i_entry[SW-1:0];

    assign w_vld     = r_rd_data[KW];
    assign w_match   = (r_rd_data[KW-1:0] == r_key);
    assign w_last    = (r_way == (r_ways - WW'(1)));
    assign w_clr_end = (r_clr == SW'(DEPTH - 1));
    assign w_insert  = (r_op == hbkt_pkg::OP_INSERT);

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_slot  = r_out_slot;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        case (r_state)
            S_INIT, S_CLR: begin
                w_we = 1'b1;
            end
            S_CHK: begin
                if (!w_vld && w_insert) begin
                    w_we    = 1'b1;
                    w_waddr = r_addr;
                    w_wdata = {1'b1, r_key};
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_FIN the output register is handled below
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_clr <= r_clr + SW'(1);
                    if (w_clr_end) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_op   <= w_e_op;
                        r_key  <= w_e_key;
                        r_ways <= w_e_ways;
                        r_way  <= '0;
                        r_addr <= w_e_base;
                        r_clr  <= '0;
                        r_hit  <= 1'b0;
                        r_slot <= '0;
                        unique case (w_e_op) inside
                            hbkt_pkg::OP_FIND, hbkt_pkg::OP_INSERT: r_state <= S_RD;
                            hbkt_pkg::OP_CLEAR:                     r_state <= S_CLR;
                            default:                                r_state <= S_FIN;
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (!w_vld) begin
                        // first empty way ends the scan; insert claims it
                        r_hit   <= w_insert;
                        r_slot  <= w_insert ? r_addr : '0;
                        r_state <= S_FIN;
                    end else if (w_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_addr;
                        r_state <= S_FIN;
                    end else if (w_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_way   <= r_way + WW'(1);
                        r_addr  <= r_addr + SW'(1);
                        r_state <= S_RD;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + SW'(1);
                    if (w_clr_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_slot  <= hbkt_pkg::SLOT_OUT_W'(r_slot);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/bucketed_hash_key_table_unit.sv @@
// Bucketed hash table of keys with find, insert and clear.
//
// Input stream (s_axis): tuser carries the operation (find, insert or
// clear whole table), tdata the key. Output stream (m_axis): one word per
// input word, in order; tuser is the hit flag, tdata the slot index
// (bucket * ways + way), zero on a miss, a full bucket or a clear.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write bucket_count (0)
// and ways_in_use (1); write them only while the block is idle.
//
// A front stage latches the word and reduces the key modulo the bucket
// count bit-serially, then forms the bucket base with one multiply. A
// two-entry queue hands the job to the back stage, which scans the ways in
// the slot memory, reading and then checking each way, and writes on insert.
// For a find or insert the bit-serial front is the slower stage and sets the
// sustained rate; it takes no new word until the last one is in the queue.
// A clear sweeps every slot of the slot memory (NUM_BUCKETS * MAX_WAYS,
// 8192 by default). After reset the same sweep runs with s_axis_tready low.
// When m_axis stalls, one result is held in the output register, one in the
// back stage, and the queue and front keep accepting until they fill.
`default_nettype none

module bucketed_hash_key_table_unit #(
    parameter int NUM_BUCKETS = 1024,
    parameter int MAX_WAYS    = 8,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hbkt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [hbkt_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [hbkt_pkg::KEY_IN_W-1:0]        s_axis_tdata,  // [31:0] key
    input  wire logic [hbkt_pkg::OP_W-1:0]            s_axis_tuser,  // [1:0] operation
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [hbkt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,  // [12:0] slot_index
    output logic [0:0]                                m_axis_tuser   // [0] hit
);

    localparam int KW    = (KEY_WIDTH < hbkt_pkg::KEY_IN_W) ? KEY_WIDTH : hbkt_pkg::KEY_IN_W;
    localparam int WW    = $clog2(MAX_WAYS + 1);
    localparam int DEPTH = NUM_BUCKETS * MAX_WAYS;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = hbkt_pkg::OP_W + KW + WW + SW;

    logic [hbkt_pkg::BUCKET_CFG_W-1:0] r_bucket_count;
    logic [hbkt_pkg::WAYS_CFG_W-1:0]   r_ways_in_use;

    logic                            w_push;
    logic [EW-1:0]                   w_push_data;
    logic                            w_full;
    logic                            w_pop;
    logic [EW-1:0]                   w_pop_data;
    logic                            w_empty;
    logic                            w_init_busy;
    logic                            w_out_hit;
    logic [hbkt_pkg::SLOT_OUT_W-1:0] w_out_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= hbkt_pkg::BUCKET_COUNT_RESET;
            r_ways_in_use  <= hbkt_pkg::WAYS_IN_USE_RESET;
        end else if (i_cfg_we) begin
            unique case (hbkt_pkg::t_cfg_idx'(i_cfg_idx))
                hbkt_pkg::CFG_BUCKET_COUNT: begin
                    r_bucket_count <= i_cfg_data[hbkt_pkg::BUCKET_CFG_W-1:0];
                end
                hbkt_pkg::CFG_WAYS_IN_USE: begin
                    r_ways_in_use <= i_cfg_data[hbkt_pkg::WAYS_CFG_W-1:0];
                end
                default: r_ways_in_use <= r_ways_in_use;
            endcase
        end
    end

    hbkt_front #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .MAX_WAYS    (MAX_WAYS),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_ways_in_use  (r_ways_in_use),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_key          (s_axis_tdata),
        .i_hold         (w_init_busy),
        .o_push         (w_push),
        .o_entry        (w_push_data),
        .i_full         (w_full)
    );

    hbkt_fifo #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    hbkt_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .MAX_WAYS    (MAX_WAYS),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_pop_data),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_hit   (w_out_hit),
        .o_out_slot  (w_out_slot)
    );

    assign m_axis_tdata = hbkt_pkg::OUT_TDATA_W'(w_out_slot);
    assign m_axis_tuser = w_out_hit;

endmodule

`default_nettype wire

@@ rtl/hbkt_checker.sv @@
`default_nettype none

module hbkt_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [hbkt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]                       m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a miss always reports slot zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero slot index on a miss");

    // slot memory sweep right after reset: no input taken
    a_init_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("input accepted during reset sweep");

    // no result word right after reset
    a_init_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result shown right after reset");

endmodule

bind bucketed_hash_key_table_unit hbkt_checker u_hbkt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ sim/bucketed_hash_key_table_unit_tb.sv @@
`default_nettype none

module bucketed_hash_key_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [hbkt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int TABLE_DEPTH    = 1024 * 8;
    localparam int PHASE_WORDS    = 250;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 30000;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct packed {
        logic                            hit;
        logic [hbkt_pkg::SLOT_OUT_W-1:0] slot;
    } t_lookup_result;

    class key_table_scoreboard;
        bit                                slot_used[TABLE_DEPTH];
        logic [hbkt_pkg::KEY_IN_W-1:0]     slot_key[TABLE_DEPTH];
        logic [hbkt_pkg::BUCKET_CFG_W-1:0] bucket_reg;
        logic [hbkt_pkg::WAYS_CFG_W-1:0]   ways_reg;
        t_lookup_result                    expected_q[$];
        int unsigned                       mismatches;

        function new();
            slot_used  = '{default: 1'b0};
            bucket_reg = hbkt_pkg::BUCKET_COUNT_RESET;
            ways_reg   = hbkt_pkg::WAYS_IN_USE_RESET;
            mismatches = 0;
        endfunction

        function int unsigned live_buckets();
            if (bucket_reg == 0) return 1;
            if (bucket_reg > 1024) return 1024;
            return 32'(bucket_reg);
        endfunction

        function int unsigned live_ways();
            if (ways_reg == 0) return 1;
            if (ways_reg > 8) return 8;
            return 32'(ways_reg);
        endfunction

        function void set_reg(hbkt_pkg::t_cfg_idx idx,
                              logic [hbkt_pkg::CFG_DATA_W-1:0] val);
            if (idx == hbkt_pkg::CFG_BUCKET_COUNT) bucket_reg = val;
            else ways_reg = val[hbkt_pkg::WAYS_CFG_W-1:0];
        endfunction

        // scan the bucket in way order; an insert claims the first empty way
        function bit scan_bucket(logic [hbkt_pkg::KEY_IN_W-1:0] key, bit claim,
                                 output logic [hbkt_pkg::SLOT_OUT_W-1:0] where);
            int unsigned nw;
            int unsigned base;
            int unsigned s;
            nw   = live_ways();
            base = (key % live_buckets()) * nw;
            where = '0;
            for (int unsigned w = 0; w < nw; w++) begin
                s = base + w;
                if (!slot_used[s]) begin
                    if (!claim) return 1'b0;
                    slot_used[s] = 1'b1;
                    slot_key[s]  = key;
                    where = s[hbkt_pkg::SLOT_OUT_W-1:0];
                    return 1'b1;
                end
                if (slot_key[s] == key) begin
                    where = s[hbkt_pkg::SLOT_OUT_W-1:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_word(logic [hbkt_pkg::OP_W-1:0] op,
                                logic [hbkt_pkg::KEY_IN_W-1:0] key);
            t_lookup_result r;
            logic [hbkt_pkg::SLOT_OUT_W-1:0] where;
            r = '0;
            case (op)
                hbkt_pkg::OP_FIND:   r.hit = scan_bucket(key, 1'b0, where);
                hbkt_pkg::OP_INSERT: r.hit = scan_bucket(key, 1'b1, where);
                hbkt_pkg::OP_CLEAR:  slot_used = '{default: 1'b0};
                default:             ;
            endcase
            if (r.hit) r.slot = where;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_word(logic hit, logic [hbkt_pkg::OUT_TDATA_W-1:0] tdata);
            t_lookup_result e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing pending: hit=%0d tdata=0x%04h",
                             hit, tdata);
                return;
            end
            e = expected_q.pop_front();
            if (hit !== e.hit ||
                tdata !== {{(hbkt_pkg::OUT_TDATA_W-hbkt_pkg::SLOT_OUT_W){1'b0}}, e.slot})
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("wrong result: expected hit=%0d slot=%0d, got hit=%0d tdata=0x%04h",
                             e.hit, e.slot, hit, tdata);
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [hbkt_pkg::CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [hbkt_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [hbkt_pkg::KEY_IN_W-1:0]     s_axis_tdata = '0;
    logic [hbkt_pkg::OP_W-1:0]         s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [hbkt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]                        m_axis_tuser;

    key_table_scoreboard               sb;
    logic [hbkt_pkg::KEY_IN_W-1:0]     placed_keys[$];
    bit                                hold_req = 1'b0;
    bit                                rx_steady = 1'b0;
    int unsigned                       clears_left = 4;

    bucketed_hash_key_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 30);
        return $urandom_range(60, 200);
    endfunction

    function automatic logic [hbkt_pkg::OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 999);
        if (r < 450) return hbkt_pkg::OP_INSERT;
        if (r < 900) return hbkt_pkg::OP_FIND;
        if (r < 960) return OP_UNUSED;
        if (r >= 996 && clears_left > 0) begin
            clears_left--;
            return hbkt_pkg::OP_CLEAR;
        end
        return hbkt_pkg::OP_FIND;
    endfunction

    // keys crowd into a few buckets so ways fill up and buckets overflow
    function automatic logic [hbkt_pkg::KEY_IN_W-1:0] pick_key();
        int unsigned r;
        int unsigned nb;
        int unsigned b;
        r  = $urandom_range(0, 99);
        nb = sb.live_buckets();
        if (r < 30 && placed_keys.size() > 0)
            return placed_keys[$urandom_range(0, placed_keys.size() - 1)];
        if (r < 80) begin
            if ($urandom_range(0, 3) == 0) b = nb - 1;
            else b = $urandom_range(0, (nb < 4) ? nb - 1 : 3);
            return b + nb * $urandom_range(0, 11);
        end
        return $urandom();
    endfunction

    task automatic send_word(input logic [hbkt_pkg::OP_W-1:0] op,
                             input logic [hbkt_pkg::KEY_IN_W-1:0] key);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= key;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(op, key);
        if (op == hbkt_pkg::OP_INSERT) begin
            placed_keys.insert(placed_keys.size(), key);
            if (placed_keys.size() > 64) void'(placed_keys.pop_front());
        end
    endtask

    task automatic idle_gap(input int unsigned n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input hbkt_pkg::t_cfg_idx idx,
                             input logic [hbkt_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_and_configure(input logic [hbkt_pkg::CFG_DATA_W-1:0] buckets,
                                       input logic [hbkt_pkg::CFG_DATA_W-1:0] ways);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(hbkt_pkg::CFG_BUCKET_COUNT, buckets);
        write_reg(hbkt_pkg::CFG_WAYS_IN_USE, ways);
    endtask

    task automatic directed_word(input logic [hbkt_pkg::OP_W-1:0] op,
                                 input logic [hbkt_pkg::KEY_IN_W-1:0] key);
        send_word(op, key);
        idle_gap(rand_gap());
    endtask

    initial begin
        logic [hbkt_pkg::CFG_DATA_W-1:0] phase_buckets[7];
        logic [hbkt_pkg::CFG_DATA_W-1:0] phase_ways[7];
        sb = new();
        phase_buckets = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd0, 11'd0, 11'd1024};
        phase_ways    = '{11'd8, 11'd8, 11'd0, 11'd15, 11'd0, 11'd0, 11'd1};
        phase_buckets[4] = hbkt_pkg::CFG_DATA_W'($urandom_range(2, 16));
        phase_ways[4]    = hbkt_pkg::CFG_DATA_W'($urandom_range(1, 8));
        phase_buckets[5] = hbkt_pkg::CFG_DATA_W'($urandom_range(1, 1024));
        phase_ways[5]    = hbkt_pkg::CFG_DATA_W'($urandom_range(1, 8));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 1024 buckets, 5 ways
        directed_word(hbkt_pkg::OP_FIND, 32'd0);
        directed_word(hbkt_pkg::OP_INSERT, 32'd0);
        directed_word(hbkt_pkg::OP_INSERT, 32'd0);
        directed_word(hbkt_pkg::OP_FIND, 32'd0);
        for (int k = 1; k <= 4; k++) directed_word(hbkt_pkg::OP_INSERT, k * 1024);
        directed_word(hbkt_pkg::OP_INSERT, 32'd5120);     // bucket full of other keys
        directed_word(hbkt_pkg::OP_FIND, 32'd5120);
        directed_word(hbkt_pkg::OP_INSERT, 32'hFFFF_FFFF);
        directed_word(hbkt_pkg::OP_FIND, 32'hFFFF_FFFF);
        directed_word(hbkt_pkg::OP_FIND, 32'hFFFF_FBFF);  // same bucket, stops at empty way
        directed_word(OP_UNUSED, 32'd0);
        directed_word(hbkt_pkg::OP_CLEAR, 32'hA5A5_5A5A);
        directed_word(hbkt_pkg::OP_FIND, 32'd0);

        // oversize registers clamp to 1024 buckets x 8 ways; fill the last bucket
        drain_and_configure(11'd2047, 11'd15);
        for (int k = 0; k < 9; k++) directed_word(hbkt_pkg::OP_INSERT, 1023 + k * 1024);

        for (int p = 0; p < 7; p++) begin
            drain_and_configure(phase_buckets[p], phase_ways[p]);
            rx_steady = (p == 1 || p == 5);
            // receiver stalls long while the sender keeps offering words
            if (p == 1) hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(pick_op(), pick_key());
                if (p != 1 && p != 5) idle_gap(rand_gap());
            end
        end
        rx_steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("bucketed_hash_key_table_unit: match");
        else
            $display("bucketed_hash_key_table_unit: mismatch");
        $finish;
    end

    initial begin
        int unsigned hold_cnt;
        int unsigned rx_gap;
        hold_cnt = 0;
        rx_gap   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_word(m_axis_tuser[0], m_axis_tdata);
                if (!rx_steady) rx_gap = rand_gap();
            end
            if (hold_req) begin
                hold_cnt = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("bucketed_hash_key_table_unit: mismatch");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
